/* hdl/rfhp_pkg.sv */
`default_nettype none

package rfhp_pkg;

  // Magic word "URPC" as the little-endian word of its four bytes.
  localparam logic [31:0] MAGIC_WORD = 32'h4350_5255;

  // Header byte positions.
  localparam logic [4:0] MAGIC_LAST  = 5'd3;
  localparam logic [4:0] VERSION_POS = 5'd4;
  localparam logic [4:0] ID_FIRST    = 5'd5;
  localparam logic [4:0] LEN_FIRST   = 5'd12;

  // Result status codes.
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_MAGIC   = 2'd1;
  localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [55:0] call_id;
    logic [31:0] control_length;
    logic [31:0] message_length;
    logic [4:0]  header_bytes;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_beat_t;

endpackage

`default_nettype wire

/* hdl/rfhp_parser.sv */
`default_nettype none

module rfhp_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  frame_start,
  output rfhp_pkg::result_beat_t     result
);

  logic [4:0]  byte_position, byte_position_next;
  logic        parsing_active, parsing_active_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [55:0] id_shift, id_shift_next;
  logic [31:0] control_shift, control_shift_next;
  logic [31:0] message_shift, message_shift_next;
  logic [1:0]  control_count_less_one, control_count_less_one_next;
  logic [1:0]  message_count_less_one, message_count_less_one_next;

  logic        active;
  logic [4:0]  pos;
  logic [4:0]  id_off;
  logic [4:0]  ctrl_off;
  logic [4:0]  msg_off;
  logic [2:0]  cbytes;
  logic [2:0]  mbytes;
  logic [4:0]  ctrl_end;
  logic [4:0]  msg_end;

  always_comb begin
    active = frame_start | parsing_active;
    pos    = frame_start ? 5'd0 : byte_position;

    // A start byte begins from a cleared frame.
    magic_shift_next            = frame_start ? 32'd0 : magic_shift;
    id_shift_next               = frame_start ? 56'd0 : id_shift;
    control_shift_next          = frame_start ? 32'd0 : control_shift;
    message_shift_next          = frame_start ? 32'd0 : message_shift;
    control_count_less_one_next = frame_start ? 2'd0 : control_count_less_one;
    message_count_less_one_next = frame_start ? 2'd0 : message_count_less_one;

    cbytes   = frame_start ? 3'd1 : {1'b0, control_count_less_one} + 3'd1;
    mbytes   = frame_start ? 3'd1 : {1'b0, message_count_less_one} + 3'd1;
    ctrl_end = rfhp_pkg::LEN_FIRST + {2'b00, cbytes};
    msg_end  = ctrl_end + {2'b00, mbytes};
    id_off   = pos - rfhp_pkg::ID_FIRST;
    ctrl_off = pos - rfhp_pkg::LEN_FIRST;
    msg_off  = pos - ctrl_end;

    byte_position_next  = byte_position;
    parsing_active_next = parsing_active;

    result.valid                    = 1'b0;
    result.data.status              = rfhp_pkg::STATUS_OK;
    result.data.call_id             = 56'd0;
    result.data.control_length      = 32'd0;
    result.data.message_length      = 32'd0;
    result.data.header_bytes        = 5'd0;

    if (active) begin
      parsing_active_next = 1'b1;
      byte_position_next  = pos + 5'd1;
      if (pos <= rfhp_pkg::MAGIC_LAST) begin
        magic_shift_next[{pos[1:0], 3'b000} +: 8] = data_byte;
        if (pos == rfhp_pkg::MAGIC_LAST && magic_shift_next != rfhp_pkg::MAGIC_WORD) begin
          result.valid        = 1'b1;
          result.data.status  = rfhp_pkg::STATUS_BAD_MAGIC;
          parsing_active_next = 1'b0;
        end
      end else if (pos == rfhp_pkg::VERSION_POS) begin
        if (data_byte[7:4] != 4'd0) begin
          result.valid        = 1'b1;
          result.data.status  = rfhp_pkg::STATUS_BAD_VERSION;
          parsing_active_next = 1'b0;
        end else begin
          control_count_less_one_next = data_byte[1:0];
          message_count_less_one_next = data_byte[3:2];
        end
      end else if (pos < rfhp_pkg::LEN_FIRST) begin
        id_shift_next[{id_off[2:0], 3'b000} +: 8] = data_byte;
      end else if (pos < ctrl_end) begin
        control_shift_next[{ctrl_off[1:0], 3'b000} +: 8] = data_byte;
      end else if (pos < msg_end) begin
        message_shift_next[{msg_off[1:0], 3'b000} +: 8] = data_byte;
        if (pos == msg_end - 5'd1) begin
          result.valid               = 1'b1;
          result.data.status         = rfhp_pkg::STATUS_OK;
          result.data.call_id        = id_shift_next;
          result.data.control_length = control_shift_next;
          result.data.message_length = message_shift_next;
          result.data.header_bytes   = msg_end;
          parsing_active_next        = 1'b0;
        end
      end else begin
        // Past the end of a header; the ok result always stops the parse first.
        parsing_active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position          <= 5'd0;
      parsing_active         <= 1'b0;
      magic_shift            <= 32'd0;
      id_shift               <= 56'd0;
      control_shift          <= 32'd0;
      message_shift          <= 32'd0;
      control_count_less_one <= 2'd0;
      message_count_less_one <= 2'd0;
    end else if (accept) begin
      byte_position          <= byte_position_next;
      parsing_active         <= parsing_active_next;
      magic_shift            <= magic_shift_next;
      id_shift               <= id_shift_next;
      control_shift          <= control_shift_next;
      message_shift          <= message_shift_next;
      control_count_less_one <= control_count_less_one_next;
      message_count_less_one <= message_count_less_one_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/rpc_frame_header_parser_core.sv */
`default_nettype none

// RPC frame header parser. Bytes enter one beat per cycle on the input channel; a beat with
// frame_start high is header byte 0 and restarts any parse in progress. The header is the magic
// word "URPC", a version byte whose high nibble must be zero (bits 1:0 and 3:2 give the control
// and message length byte counts minus one), a 7-byte little-endian call id, and the two
// little-endian lengths. Each frame not cut short by a new start gives exactly one result beat:
// bad magic after the fourth byte, bad version on the version byte, or ok on the last length byte,
// with the other fields zero on an error. Bytes outside a frame are consumed and ignored. Each
// accepted byte only updates the parser's position counter and shift registers in the cycle it
// is accepted, so a new byte can be taken every cycle while input is not held off. A result is
// registered into the output register, or into the skid register behind it if the output is
// stalled. The output has a register and a skid register; input is held off only while the skid
// register is occupied, i.e. after the output has stalled with a second result waiting behind the first.

module rpc_frame_header_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output wire logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  output wire logic        out_valid,
  input  wire logic        out_ready,
  output wire logic [1:0]  status,
  output wire logic [55:0] call_id,
  output wire logic [31:0] control_length,
  output wire logic [31:0] message_length,
  output wire logic [4:0]  header_bytes
);

  logic                   accept;
  rfhp_pkg::result_beat_t result;

  logic                   out_full;
  rfhp_pkg::result_t      out_data;
  logic                   skid_full;
  rfhp_pkg::result_t      skid_data;

  // The input is blocked only while the skid register holds a result.
  assign in_ready = ~skid_full;
  assign accept   = in_valid & in_ready;

  rfhp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .result      (result)
  );

  // Output register with a skid register behind it. A new result only arrives while the skid
  // register is empty, so at most one of the two moves into the output register per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) begin
        skid_full <= 1'b0;
      end
    end else if (accept && result.valid) begin
      if (out_full && !out_ready) begin
        skid_full <= 1'b1;
      end else begin
        out_full <= 1'b1;
      end
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (accept && result.valid) begin
      if (out_full && !out_ready) begin
        skid_data <= result.data;
      end else begin
        out_data <= result.data;
      end
    end
  end

  assign out_valid      = out_full;
  assign status         = out_data.status;
  assign call_id        = out_data.call_id;
  assign control_length = out_data.control_length;
  assign message_length = out_data.message_length;
  assign header_bytes   = out_data.header_bytes;

  // The skid register is only ever filled behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full)
    else $error("skid register holds a result while the output register is empty");

  // A result that cannot be taken must not be overwritten by a new one.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_full && !out_ready && skid_full |=> skid_full && out_full)
    else $error("stalled results were dropped");

  // An ok header always spans 14 to 20 bytes.
  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    out_full && status == rfhp_pkg::STATUS_OK |-> header_bytes >= 5'd14 && header_bytes <= 5'd20)
    else $error("ok result with an impossible header size");

  // Error results carry zero in every other field.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_full && status != rfhp_pkg::STATUS_OK |->
      call_id == 56'd0 && control_length == 32'd0 && message_length == 32'd0 &&
      header_bytes == 5'd0 &&
      (status == rfhp_pkg::STATUS_BAD_MAGIC || status == rfhp_pkg::STATUS_BAD_VERSION))
    else $error("error result with nonzero fields or unknown status");

endmodule

`default_nettype wire

/* dv/rpc_frame_header_parser_core_tb.sv */
`timescale 1ns / 100ps

module rpc_frame_header_parser_core_tb;

  // Watchdog limit on consecutive cycles with no beat accepted on either channel. The slowest
  // correct stretch is a sender gap plus a receiver stall plus the wait in the result register,
  // so this leaves a wide margin.
  localparam int IDLE_LIMIT = 4000;
  // Cycles to wait after the last expected result, to catch any stray extra result beat.
  localparam int DRAIN_CYCLES = 16;
  // Rough number of header bytes to send in the random part.
  localparam int RANDOM_BYTES = 1000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_RUNS} rx_mode_t;
  typedef enum int {
    FRAME_GOOD, FRAME_BAD_MAGIC, FRAME_BAD_VERSION, FRAME_CUT_SHORT, FRAME_JUNK
  } frame_kind_t;

  // Scoreboard: tracks the parser state on its own, turns each accepted byte into the header
  // result it should cause, and matches result beats against those in order.
  class header_scoreboard;
    rfhp_pkg::result_t pending_headers[$];
    logic [4:0]  position;
    bit          collecting;
    logic [31:0] magic;
    logic [55:0] id;
    logic [31:0] ctrl_len;
    logic [31:0] msg_len;
    logic [1:0]  ctrl_less_one;
    logic [1:0]  msg_less_one;
    int unsigned mismatches;

    function new();
      clear_frame();
      collecting = 0;
      mismatches = 0;
    endfunction

    function void clear_frame();
      position = '0;
      magic = '0;
      id = '0;
      ctrl_len = '0;
      msg_len = '0;
      ctrl_less_one = '0;
      msg_less_one = '0;
    endfunction

    function void finish_frame(rfhp_pkg::result_t r);
      pending_headers.push_back(r);
      collecting = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      logic [4:0] pos;
      logic [4:0] cbytes;
      logic [4:0] mbytes;
      rfhp_pkg::result_t r;
      if (start) begin
        clear_frame();
        collecting = 1;
      end
      if (!collecting) return;
      pos = position;
      cbytes = {3'b000, ctrl_less_one} + 5'd1;
      mbytes = {3'b000, msg_less_one} + 5'd1;
      position = position + 5'd1;
      r = '0;
      if (pos <= rfhp_pkg::MAGIC_LAST) begin
        magic[8*pos +: 8] = b;
        if (pos == rfhp_pkg::MAGIC_LAST && magic != rfhp_pkg::MAGIC_WORD) begin
          r.status = rfhp_pkg::STATUS_BAD_MAGIC;
          finish_frame(r);
        end
      end else if (pos == rfhp_pkg::VERSION_POS) begin
        if (b[7:4] != 4'h0) begin
          r.status = rfhp_pkg::STATUS_BAD_VERSION;
          finish_frame(r);
        end else begin
          ctrl_less_one = b[1:0];
          msg_less_one = b[3:2];
        end
      end else if (pos < rfhp_pkg::LEN_FIRST) begin
        id[8*(pos - rfhp_pkg::ID_FIRST) +: 8] = b;
      end else if (pos < rfhp_pkg::LEN_FIRST + cbytes) begin
        ctrl_len[8*(pos - rfhp_pkg::LEN_FIRST) +: 8] = b;
      end else if (pos < rfhp_pkg::LEN_FIRST + cbytes + mbytes) begin
        msg_len[8*(pos - rfhp_pkg::LEN_FIRST - cbytes) +: 8] = b;
        if (pos == rfhp_pkg::LEN_FIRST + cbytes + mbytes - 5'd1) begin
          r.status = rfhp_pkg::STATUS_OK;
          r.call_id = id;
          r.control_length = ctrl_len;
          r.message_length = msg_len;
          r.header_bytes = rfhp_pkg::LEN_FIRST + cbytes + mbytes;
          finish_frame(r);
        end
      end else begin
        collecting = 0;
      end
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(rfhp_pkg::result_t got);
      rfhp_pkg::result_t want;
      if (pending_headers.size() == 0) begin
        flag_mismatch($sformatf("result beat with none pending: status=%0d call_id=%h",
                                got.status, got.call_id));
        return;
      end
      want = pending_headers.pop_front();
      if (got.status != want.status)
        flag_mismatch($sformatf("status exp %0d got %0d", want.status, got.status));
      if (got.call_id != want.call_id)
        flag_mismatch($sformatf("call_id exp %h got %h", want.call_id, got.call_id));
      if (got.control_length != want.control_length)
        flag_mismatch($sformatf("control_length exp %h got %h",
                                want.control_length, got.control_length));
      if (got.message_length != want.message_length)
        flag_mismatch($sformatf("message_length exp %h got %h",
                                want.message_length, got.message_length));
      if (got.header_bytes != want.header_bytes)
        flag_mismatch($sformatf("header_bytes exp %0d got %0d",
                                want.header_bytes, got.header_bytes));
    endfunction

    function int outstanding();
      return pending_headers.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [55:0] call_id;
  logic [31:0] control_length;
  logic [31:0] message_length;
  logic [4:0]  header_bytes;

  rpc_frame_header_parser_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .frame_start   (frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .call_id       (call_id),
    .control_length(control_length),
    .message_length(message_length),
    .header_bytes  (header_bytes)
  );

  header_scoreboard sb = new();

  int       burst_left = 0;
  int       idle_cycles = 0;
  int       frame_bytes = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_run_left = 0;
  bit       rx_hold = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // All inputs start at known values; reset is held high at first and then released at a
  // falling edge, never to be raised again.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    frame_start = 1'b0;
    out_ready = 1'b0;
  end

  // The receiver changes its mind on a pattern of its own: long stretches where it is always
  // ready, stretches where it is ready on two random draws in three, and stretches of runs of
  // stalls. Only one assignment to out_ready happens at each falling edge.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_RANDOM: begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
      default: begin
        if (rx_run_left == 0) begin
          rx_hold = ~rx_hold;
          rx_run_left = rx_hold ? $urandom_range(1, 6) : $urandom_range(1, 12);
        end
        rx_run_left--;
        out_ready <= rx_hold;
      end
    endcase
  end

  // Every result beat taken by the receiver goes to the scoreboard. Values are read at the
  // rising edge, before the block's registers move.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{status, call_id, control_length, message_length, header_bytes});
  end

  // Watchdog: a run that stops moving beats on both channels for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one byte beat. The sender works in bursts; between bursts it may drop valid for a
  // random gap. Within a burst valid stays high and the next byte is presented at the falling
  // edge right after the previous one was taken.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    frame_start <= start;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, start);
  endtask

  function automatic logic [7:0] magic_byte(int i);
    return rfhp_pkg::MAGIC_WORD[8*i +: 8];
  endfunction

  // Header content bytes lean on the extremes so that all-zero and all-one lengths and ids
  // show up often.
  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random frame. Most are well formed with random version bits and content; the rest are
  // broken: a corrupted magic byte, a nonzero version high nibble, a header cut short by the
  // next start, or a burst of arbitrary bytes. Error frames sometimes carry on with the rest of
  // the header, which the parser must ignore.
  task automatic send_random_frame();
    logic [7:0]  hdr [20];
    logic [7:0]  ver;
    logic [7:0]  flip;
    int          len;
    int          count;
    int          useful;
    int          j;
    frame_kind_t kind;
    j = $urandom_range(0, 9);
    kind = (j < 6) ? FRAME_GOOD : frame_kind_t'(j - 5);
    ver = {4'h0, 4'($urandom_range(0, 15))};
    len = 12 + ver[1:0] + 1 + ver[3:2] + 1;
    for (int i = 0; i < 20; i++)
      hdr[i] = (i < 4) ? magic_byte(i) : (i == 4) ? ver : content_byte();
    count = len;
    useful = len;
    case (kind)
      FRAME_BAD_MAGIC: begin
        j = $urandom_range(0, 3);
        flip = 8'($urandom_range(1, 255));
        hdr[j] = hdr[j] ^ flip;
        useful = 4;
        count = $urandom_range(0, 1) ? 4 : len;
      end
      FRAME_BAD_VERSION: begin
        hdr[4][7:4] = 4'($urandom_range(1, 15));
        useful = 5;
        count = $urandom_range(0, 1) ? 5 : len;
      end
      FRAME_CUT_SHORT: begin
        count = $urandom_range(1, len - 1);
        useful = count;
      end
      FRAME_JUNK: begin
        for (int i = 0; i < 20; i++) hdr[i] = 8'($urandom_range(0, 255));
        count = $urandom_range(1, 6);
        useful = count;
      end
      default: ;
    endcase
    for (int i = 0; i < count; i++) send_byte(hdr[i], i == 0);
    frame_bytes += useful;
    // Bytes with no start flag between frames. After a finished header they are ignored;
    // after a header cut short they keep feeding the open parse.
    if ($urandom_range(0, 3) == 0) begin
      count = $urandom_range(1, 4);
      for (int i = 0; i < count; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A stray byte while idle, an all-ones bad magic word, a bad version with
    // the high nibble set, a restart two bytes into a header, and the shortest valid header
    // with every field zero.
    send_byte(8'hFF, 1'b0);
    for (int i = 0; i < 4; i++) send_byte(8'hFF, i == 0);
    for (int i = 0; i < 5; i++) send_byte((i < 4) ? magic_byte(i) : 8'hF0, i == 0);
    for (int i = 0; i < 2; i++) send_byte(magic_byte(i), i == 0);
    for (int i = 0; i < 14; i++) send_byte((i < 4) ? magic_byte(i) : 8'h00, i == 0);

    while (frame_bytes < RANDOM_BYTES) send_random_frame();

    @(negedge clk);
    in_valid <= 1'b0;
    frame_start <= 1'b0;

    // Drain: the watchdog covers a result that never comes.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rfhp_pkg.sv
hdl/rfhp_parser.sv
hdl/rpc_frame_header_parser_core.sv
dv/rpc_frame_header_parser_core_tb.sv
